FILE: hw/rtl/bfba_pkg.sv
// Package for the best-fit bitmap allocator: item types, status codes, FSM states.
// No dependencies.
`default_nettype none
package bfba_pkg;
    localparam int WordW = 32;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_FREED     = 2'd2,
        ST_IGNORED   = 2'd3
    } t_status;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } t_mode;

    typedef struct packed {
        logic        mode;
        logic [11:0] request_size;
        logic [11:0] base_address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] placed_address;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK_RD,
        S_MARK_WR,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

FILE: hw/rtl/best_fit_bitmap_allocator_core.sv
// Top level of the best-fit bitmap allocator: occupancy map in a word-wide RAM.
// Depends on bfba_pkg.
//
// channel | direction | signals
// item in | in        | i_start, o_busy, i_item
// result  | out       | o_valid, o_result
//
// After reset a clearing pass writes one word per cycle over the whole map, busy all the while.
// Allocate: scan one bit per cycle, after a fetch of the first word and one step past the last
// unit to close the final run, then read and write each touched word to mark it.
// Free: read and write each touched word. Every item then passes through the done state and
// the result strobe follows in the first idle cycle; the receiver cannot stall.
`default_nettype none
module best_fit_bitmap_allocator_core #(
    parameter int MEM_UNITS = 2048
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    output logic                      o_busy,
    input  wire bfba_pkg::t_in_item   i_item,
    output logic                      o_valid,
    output bfba_pkg::t_out_item       o_result
);
    import bfba_pkg::*;

    localparam int Words = (MEM_UNITS + WordW - 1) / WordW;
    localparam int AW    = (Words > 1) ? $clog2(Words) : 1;
    localparam int UW    = $clog2(MEM_UNITS + 1);   // holds MEM_UNITS itself
    localparam int BW    = $clog2(WordW);

    // word-wide occupancy memory
    logic [WordW-1:0] r_mem [Words];
    logic [WordW-1:0] r_rdata;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [WordW-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[mem_raddr];
    end

    t_state     r_state, n_state;
    logic       r_mode;
    logic [UW-1:0] r_size, r_u, n_u, r_end;
    logic [UW-1:0] r_run_len, r_run_base, r_best_len, r_best_base;
    logic       r_found;
    logic       r_rd_ok;          // r_rdata holds word of r_u
    logic [1:0] r_status;
    logic [10:0] r_placed;

    wire [UW+12:0] size_w = {{(UW+1){1'b0}}, i_item.request_size};
    wire [UW+12:0] base_w = {{(UW+1){1'b0}}, i_item.base_address};
    wire [AW-1:0]  u_word = AW'(r_u >> BW);
    wire [BW-1:0]  u_bit  = r_u[BW-1:0];
    wire           at_end = (r_u == UW'(MEM_UNITS));
    wire           bit_free = !at_end && !r_rdata[u_bit];
    // current run closes as the best one so far
    wire           take_run = (r_run_len >= r_size) && (r_run_len != '0) &&
                              (!r_found || (r_run_len < r_best_len));
    // allocate that cannot fit anywhere
    wire           no_alloc = (i_item.request_size == '0) ||
                              (size_w > (UW+13)'(MEM_UNITS));
    // free with a negative base or a base past the end
    wire           ignore_free = i_item.base_address[11] ||
                                 (base_w >= (UW+13)'(MEM_UNITS));

    // mask for the current word in the range [r_u, r_end)
    logic [WordW-1:0] rng_mask;
    always_comb begin
        for (int b = 0; b < WordW; b++) begin
            rng_mask[b] = ({1'b0, u_word, BW'(b)} >= (AW+BW+1)'(r_u)) &&
                          ({1'b0, u_word, BW'(b)} <  (AW+BW+1)'(r_end)) &&
                          (({1'b0, u_word, BW'(b)}) < (AW+BW+1)'(MEM_UNITS));
        end
    end

    // next state and memory control
    always_comb begin
        n_state   = r_state;
        n_u       = r_u;
        mem_we    = 1'b0;
        mem_waddr = u_word;
        mem_raddr = u_word;
        mem_wdata = r_mode ? (r_rdata & ~rng_mask) : (r_rdata | rng_mask);
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                n_u       = r_u + UW'(WordW);
                if (u_word == AW'(Words - 1)) begin
                    n_state = S_IDLE;
                    n_u     = '0;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_item.mode == MODE_ALLOC) begin
                        n_u     = '0;
                        n_state = no_alloc ? S_DONE : S_SCAN;
                    end else if (ignore_free) begin
                        n_state = S_DONE;
                    end else begin
                        n_u     = UW'(i_item.base_address);
                        n_state = (i_item.request_size == '0) ? S_DONE : S_MARK_RD;
                    end
                end
            end
            S_SCAN: begin
                mem_raddr = AW'((r_u + UW'(1)) >> BW);
                if (r_rd_ok) begin
                    if (at_end) begin
                        // pick best run, or finish with no fit
                        if (take_run) begin
                            n_state = S_MARK_RD;
                            n_u     = r_run_base;
                        end else if (r_found) begin
                            n_state = S_MARK_RD;
                            n_u     = r_best_base;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else begin
                        n_u = r_u + UW'(1);
                    end
                end
            end
            S_MARK_RD: n_state = S_MARK_WR;
            S_MARK_WR: begin
                mem_we = 1'b1;
                n_u    = UW'({u_word, BW'(0)}) + UW'(WordW);
                if (n_u >= r_end || ({1'b0, u_word} >= (AW+1)'(Words - 1))) n_state = S_DONE;
                else n_state = S_MARK_RD;
                mem_raddr = AW'(n_u >> BW);
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_u     <= '0;
            o_valid <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_u     <= n_u;
            o_valid <= (r_state == S_DONE);
            r_rd_ok <= (r_state == S_SCAN) && !(r_rd_ok && at_end);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_mode    <= i_item.mode;
                        r_size    <= UW'(i_item.request_size);
                        r_placed  <= '0;
                        r_run_len <= '0;
                        r_found   <= 1'b0;
                        if (i_item.mode == MODE_ALLOC) begin
                            r_status <= ST_NO_FIT;
                        end else if (ignore_free) begin
                            r_status <= ST_IGNORED;
                        end else begin
                            r_status <= ST_FREED;
                            r_end    <= (base_w + size_w > (UW+13)'(MEM_UNITS)) ?
                                        UW'(MEM_UNITS) : UW'(base_w + size_w);
                        end
                    end
                end
                S_SCAN: begin
                    if (r_rd_ok) begin
                        if (bit_free) begin
                            if (r_run_len == '0) r_run_base <= r_u;
                            r_run_len <= r_run_len + UW'(1);
                        end else begin
                            if (take_run) begin
                                r_found     <= 1'b1;
                                r_best_len  <= r_run_len;
                                r_best_base <= r_run_base;
                            end
                            r_run_len <= '0;
                        end
                        if (at_end) begin
                            // load the chosen run for marking
                            if (take_run) begin
                                r_status <= ST_ALLOCATED;
                                r_end    <= r_run_base + r_size;
                                r_placed <= 11'(r_run_base);
                            end else if (r_found) begin
                                r_status <= ST_ALLOCATED;
                                r_end    <= r_best_base + r_size;
                                r_placed <= 11'(r_best_base);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_result.status = r_status;
    assign o_result.placed_address = r_placed;
endmodule
`default_nettype wire

FILE: hw/rtl/bfba_checker.sv
// Port-level checks for the best-fit bitmap allocator.
// Depends on bfba_pkg; bound to best_fit_bitmap_allocator_core.
`default_nettype none
module bfba_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      i_start,
    input wire                      o_busy,
    input wire bfba_pkg::t_in_item  i_item,
    input wire                      o_valid,
    input wire bfba_pkg::t_out_item o_result
);
    import bfba_pkg::*;

    // accepted item makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("not busy after accept");
    // a result strobe is a single cycle
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("strobe longer than one cycle");
    // result comes only while the block is no longer busy
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy) else $error("busy with result shown");
    // placed address only on successful allocate
    a_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != ST_ALLOCATED) |-> o_result.placed_address == '0)
        else $error("address on failed item");
endmodule

bind best_fit_bitmap_allocator_core bfba_checker u_bfba_checker (.*);
`default_nettype wire

FILE: bench/best_fit_bitmap_allocator_core_chk.sv
// Checker for the best-fit bitmap allocator: mirrors the occupancy map, predicts
// each result and compares it with the block's output. Depends on bfba_pkg.
module best_fit_bitmap_allocator_core_chk #(
    parameter int MEM_UNITS = 2048
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire                  i_busy,
    input  bfba_pkg::t_in_item   i_item,
    input  wire                  i_valid,
    input  bfba_pkg::t_out_item  i_result,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_alloc_ok,
    output int                   o_no_fit,
    output int                   o_freed,
    output int                   o_ignored
);
    import bfba_pkg::*;

    bit        used_map [MEM_UNITS];
    t_out_item expected_q [$];

    // Find the smallest free run holding need units; lowest base wins ties.
    function automatic bit best_run(input int need, output int base);
        int  run_len;
        int  run_base;
        int  best_len;
        bit  found;
        bit  is_free;
        found = 0;
        run_len = 0;
        run_base = 0;
        best_len = 0;
        base = 0;
        for (int u = 0; u <= MEM_UNITS; u++) begin
            is_free = (u < MEM_UNITS) && !used_map[u];
            if (is_free) begin
                if (run_len == 0) run_base = u;
                run_len++;
            end else begin
                if (run_len >= need && run_len > 0 && (!found || run_len < best_len)) begin
                    found = 1;
                    best_len = run_len;
                    base = run_base;
                end
                run_len = 0;
            end
        end
        return found;
    endfunction

    // Apply one item to the mirror map and return the result it causes.
    function automatic t_out_item apply_item(input t_in_item it);
        t_out_item r;
        int        base;
        int        size;
        int        stop;
        r = '0;
        size = it.request_size;
        if (it.mode == MODE_ALLOC) begin
            if (size != 0 && best_run(size, base)) begin
                for (int u = base; u < base + size && u < MEM_UNITS; u++) used_map[u] = 1;
                r.status = ST_ALLOCATED;
                r.placed_address = base[10:0];
            end else begin
                r.status = ST_NO_FIT;
            end
        end else if (it.base_address[11] || it.base_address >= MEM_UNITS) begin
            r.status = ST_IGNORED;
        end else begin
            stop = it.base_address + size;
            if (stop > MEM_UNITS) stop = MEM_UNITS;
            for (int u = it.base_address; u < stop; u++) used_map[u] = 0;
            r.status = ST_FREED;
        end
        return r;
    endfunction

    assign o_pending = expected_q.size();

    // Predict on accepted items, compare on strobed results.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int u = 0; u < MEM_UNITS; u++) used_map[u] = 0;
            expected_q.delete();
            o_fail_count <= 0;
            o_alloc_ok <= 0;
            o_no_fit <= 0;
            o_freed <= 0;
            o_ignored <= 0;
        end else begin
            if (i_valid) begin
                if (expected_q.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected result: status %0d addr %0d",
                                 i_result.status, i_result.placed_address);
                end else begin
                    want = expected_q.pop_front();
                    if (want.status != i_result.status ||
                        want.placed_address != i_result.placed_address) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("mismatch: expected status %0d addr %0d, got %0d addr %0d",
                                     want.status, want.placed_address,
                                     i_result.status, i_result.placed_address);
                    end
                    case (want.status)
                        ST_ALLOCATED: o_alloc_ok <= o_alloc_ok + 1;
                        ST_NO_FIT:    o_no_fit <= o_no_fit + 1;
                        ST_FREED:     o_freed <= o_freed + 1;
                        default:      o_ignored <= o_ignored + 1;
                    endcase
                end
            end
            if (i_start && !i_busy) expected_q.push_back(apply_item(i_item));
        end
    end
endmodule

FILE: bench/best_fit_bitmap_allocator_core_tb.sv
// Testbench top for the best-fit bitmap allocator: drives alloc/free items
// and gives the verdict. Depends on bfba_pkg, the core and the checker.
module best_fit_bitmap_allocator_core_tb;
    import bfba_pkg::*;

    localparam int MemUnits = 2048;
    localparam int RandomItems = 1430;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    logic      o_busy;
    t_in_item  i_item;
    logic      o_valid;
    t_out_item o_result;
    int        fail_count;
    int        pending;
    int        n_alloc;
    int        n_no_fit;
    int        n_freed;
    int        n_ignored;
    int        idle_pct;
    int        n_sent;
    int        placed_q [$];
    int        size_q [$];

    best_fit_bitmap_allocator_core #(.MEM_UNITS(MemUnits)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_item(i_item), .o_valid(o_valid), .o_result(o_result)
    );

    best_fit_bitmap_allocator_core_chk #(.MEM_UNITS(MemUnits)) chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_item(i_item), .i_valid(o_valid), .i_result(o_result),
        .o_fail_count(fail_count), .o_pending(pending), .o_alloc_ok(n_alloc),
        .o_no_fit(n_no_fit), .o_freed(n_freed), .o_ignored(n_ignored)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Bound the run well past the slowest legal pace.
    initial begin
        #(64'd20 * 64'd12_000_000);
        $display("best_fit_bitmap_allocator_core verification failed");
        $finish;
    end

    // Send one item, idling first at the current rate, then wait for acceptance.
    // Start stays high until the next idle cycle or drain.
    task automatic send_item(input logic mode, input int size, input int base);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item.mode <= mode;
        i_item.request_size <= size[11:0];
        i_item.base_address <= base[11:0];
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        n_sent++;
    endtask

    // Drop start and wait for all results, so allocation addresses are known.
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Mostly sizes up to 64, sometimes anything, the extremes (zero, map size, 4095) now and then.
    function automatic int pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 75) return $urandom_range(64, 1);
        if (r < 95) return $urandom_range(4095);
        return (r < 97) ? 0 : ((r < 99) ? MemUnits : 4095);
    endfunction

    initial begin
        int r;
        int k;
        int sz;
        i_rst_n = 0;
        i_start = 0;
        i_item = '0;
        idle_pct = 0;
        n_sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, each status, each corner case.
        send_item(MODE_ALLOC, 0, 0);
        send_item(MODE_ALLOC, 4095, 0);
        send_item(MODE_ALLOC, MemUnits, 0);
        send_item(MODE_ALLOC, 1, 0);
        send_item(MODE_FREE, MemUnits, 0);
        send_item(MODE_ALLOC, 100, 0);
        send_item(MODE_ALLOC, 10, 0);
        send_item(MODE_ALLOC, 30, 0);
        send_item(MODE_FREE, 10, 100);
        send_item(MODE_FREE, 5, 0);
        send_item(MODE_ALLOC, 5, 0);
        send_item(MODE_ALLOC, 8, 0);
        send_item(MODE_FREE, 0, 50);
        send_item(MODE_FREE, 3, -1);
        send_item(MODE_FREE, 3, -2048);
        send_item(MODE_FREE, 3, 2047);
        send_item(MODE_FREE, 4095, 2040);
        send_item(MODE_FREE, 1, 4095);
        send_item(MODE_FREE, 2048, 2048);
        send_item(MODE_ALLOC, 2047, 0);
        send_item(MODE_ALLOC, 2, 0);
        send_item(MODE_FREE, 4095, 0);
        send_item(MODE_ALLOC, 4095, 0);
        drain();

        // Random: fill and free real blocks, with some noise items.
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 35 : ((ph == 1) ? 66 : 0);
            for (int n = 0; n < RandomItems / 3; n++) begin
                if ($urandom_range(19) == 0) idle_pct = 0;
                else idle_pct = (ph == 0) ? 35 : ((ph == 1) ? 66 : 0);
                r = $urandom_range(99);
                if (r < 45 || placed_q.size() == 0) begin
                    sz = pick_size();
                    send_item(MODE_ALLOC, sz, $urandom_range(4095));
                    drain();
                end else if (r < 85) begin
                    k = $urandom_range(placed_q.size() - 1);
                    send_item(MODE_FREE, size_q[k], placed_q[k]);
                    placed_q.delete(k);
                    size_q.delete(k);
                end else begin
                    send_item(MODE_FREE, $urandom_range(4095), $urandom_range(4095));
                end
            end
            drain();
        end

        repeat (MemUnits * 3) @(posedge i_clk);
        $display("covered %0d items: %0d allocated, %0d no fit, %0d freed, %0d ignored",
                 n_sent, n_alloc, n_no_fit, n_freed, n_ignored);
        if (fail_count == 0 && pending == 0) begin
            $display("best_fit_bitmap_allocator_core verification clean");
        end else begin
            $display("best_fit_bitmap_allocator_core verification failed");
        end
        $finish;
    end

    // Track where allocations landed so later frees hit real blocks.
    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy && i_item.mode == MODE_ALLOC)
            size_q.push_back(i_item.request_size);
        if (i_rst_n && o_valid && o_result.status == ST_ALLOCATED)
            placed_q.push_back(o_result.placed_address);
        else if (i_rst_n && o_valid && o_result.status == ST_NO_FIT && size_q.size() > placed_q.size())
            void'(size_q.pop_back());
    end
endmodule

FILE: filelist.f
hw/rtl/bfba_pkg.sv
hw/rtl/best_fit_bitmap_allocator_core.sv
hw/rtl/bfba_checker.sv
bench/best_fit_bitmap_allocator_core_chk.sv
bench/best_fit_bitmap_allocator_core_tb.sv
